// ===== rtl/uns_pkg.sv =====
// Shared types, constants and register codes for the UTF-8 name sanitizer.
package uns_pkg;

    // Largest output buffer the block honors; a larger byte_capacity is clamped to it.
    localparam int UNS_MAX_CAPACITY = 256;

    // Configuration register indexes.
    localparam int UNS_CFG_INDEX_W = 4;
    localparam logic [UNS_CFG_INDEX_W-1:0] UNS_REG_BYTE_CAPACITY = UNS_CFG_INDEX_W'(0);
    localparam logic [UNS_CFG_INDEX_W-1:0] UNS_REG_CHAR_LIMIT    = UNS_CFG_INDEX_W'(1);

    // Configuration reset values.
    localparam logic [8:0] UNS_CAPACITY_RESET = 9'd64;
    localparam logic [7:0] UNS_LIMIT_RESET    = 8'd32;

    // Byte codes.
    localparam logic [7:0] UNS_TAB       = 8'h09;
    localparam logic [7:0] UNS_SPACE     = 8'h20;
    localparam logic [7:0] UNS_DEL       = 8'h7F;
    localparam logic [7:0] UNS_LEAD2_LO  = 8'hC2;
    localparam logic [7:0] UNS_LEAD2_HI  = 8'hDF;
    localparam logic [7:0] UNS_LEAD3_LO  = 8'hE0;
    localparam logic [7:0] UNS_LEAD3_HI  = 8'hEF;
    localparam logic [7:0] UNS_LEAD4_LO  = 8'hF0;
    localparam logic [7:0] UNS_LEAD4_HI  = 8'hF4;
    localparam logic [7:0] UNS_C1_TOP    = 8'h9F;

    // Input request payload.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } uns_in_t;

    // Result payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_done;
        logic [8:0] out_length;
        logic       out_last;
    } uns_out_t;

    // Per-name state.
    typedef struct packed {
        logic [7:0]      lead_hold;
        logic [2:0][7:0] tail_hold;
        logic [2:0]      seq_expected;
        logic [1:0]      tail_count;
        logic            space_pending;
        logic [8:0]      bytes_used;
        logic [7:0]      chars_used;
        logic            halted;
    } uns_state_t;

    // Results caused by one input request: character bytes first, then an optional close.
    typedef struct packed {
        logic [4:0][7:0] chars;
        logic [2:0]      nchar;
        logic            done;
        logic [8:0]      length;
    } uns_bundle_t;

endpackage

// ===== rtl/uns_decode.sv =====
// Per-byte decode: UTF-8 sequence tracking, filtering, limit checks and result bundle.
module uns_decode (
    input  uns_pkg::uns_state_t  st,
    input  uns_pkg::uns_in_t     req,
    input  logic [8:0]           byte_capacity,
    input  logic [7:0]           char_limit,
    output uns_pkg::uns_state_t  st_next,
    output uns_pkg::uns_bundle_t bundle
);
    import uns_pkg::*;

    localparam logic [9:0] CapMax = 10'(UNS_MAX_CAPACITY);

    logic [7:0]      b;
    logic            close;
    logic            do_lead;
    logic            emit_req;
    logic [2:0]      emit_len;
    logic [3:0][7:0] seq;
    logic [2:0]      tc_inc;
    logic            sp;
    logic [9:0]      cap;
    logic [9:0]      byte_need;
    logic [8:0]      char_need;

    always_comb begin
        b         = req.in_byte;
        close     = req.in_last || (b == 8'd0);
        st_next   = st;
        do_lead   = 1'b0;
        emit_req  = 1'b0;
        emit_len  = 3'd0;
        seq       = '0;
        tc_inc    = {1'b0, st.tail_count} + 3'd1;
        bundle    = '0;

        // Sequence tracking and lead classification
        if (!st.halted && b != 8'd0) begin
            if (st.seq_expected != 3'd0) begin
                if (b[7:6] == 2'b10 && st.tail_count != 2'd3) begin
                    st_next.tail_hold[st.tail_count] = b;
                    if (tc_inc + 3'd1 >= st.seq_expected) begin
                        seq = {st_next.tail_hold[2], st_next.tail_hold[1],
                               st_next.tail_hold[0], st.lead_hold};
                        st_next.seq_expected = 3'd0;
                        st_next.tail_count   = 2'd0;
                        // drop C1 controls encoded as C2 80..C2 9F
                        if (!(st.lead_hold == UNS_LEAD2_LO
                              && st_next.tail_hold[0] <= UNS_C1_TOP)) begin
                            emit_req = 1'b1;
                            emit_len = st.seq_expected;
                        end
                    end else begin
                        st_next.tail_count = tc_inc[1:0];
                    end
                end else begin
                    // broken sequence: drop it and retry this byte as a lead
                    st_next.seq_expected = 3'd0;
                    st_next.tail_count   = 2'd0;
                    do_lead              = 1'b1;
                end
            end else begin
                do_lead = 1'b1;
            end

            if (do_lead) begin
                if (!b[7]) begin
                    if (b < UNS_SPACE || b == UNS_DEL) begin
                        if (b == UNS_TAB) begin
                            st_next.space_pending = 1'b1;
                        end
                    end else if (b == UNS_SPACE) begin
                        st_next.space_pending = 1'b1;
                    end else begin
                        emit_req = 1'b1;
                        emit_len = 3'd1;
                        seq[0]   = b;
                    end
                end else if (b >= UNS_LEAD2_LO && b <= UNS_LEAD2_HI) begin
                    st_next.lead_hold    = b;
                    st_next.seq_expected = 3'd2;
                    st_next.tail_count   = 2'd0;
                end else if (b >= UNS_LEAD3_LO && b <= UNS_LEAD3_HI) begin
                    st_next.lead_hold    = b;
                    st_next.seq_expected = 3'd3;
                    st_next.tail_count   = 2'd0;
                end else if (b >= UNS_LEAD4_LO && b <= UNS_LEAD4_HI) begin
                    st_next.lead_hold    = b;
                    st_next.seq_expected = 3'd4;
                    st_next.tail_count   = 2'd0;
                end
            end
        end

        // Limit check and emission
        sp        = st.space_pending && (st.bytes_used != 9'd0);
        cap       = ({1'b0, byte_capacity} > CapMax) ? CapMax : {1'b0, byte_capacity};
        byte_need = {1'b0, st.bytes_used} + {7'd0, emit_len} + {9'd0, sp} + 10'd1;
        char_need = {1'b0, st.chars_used} + 9'd1 + {8'd0, sp};
        if (emit_req) begin
            if (char_need > {1'b0, char_limit} || byte_need > cap) begin
                st_next.halted = 1'b1;
            end else begin
                st_next.space_pending = 1'b0;
                st_next.bytes_used    = st.bytes_used + {6'd0, emit_len} + {8'd0, sp};
                st_next.chars_used    = st.chars_used + 8'd1 + {7'd0, sp};
                bundle.nchar          = emit_len + {2'd0, sp};
                if (sp) begin
                    bundle.chars = {seq, UNS_SPACE};
                end else begin
                    bundle.chars = {8'd0, seq};
                end
            end
        end

        // Close the name
        if (close) begin
            bundle.done   = 1'b1;
            bundle.length = st_next.bytes_used;
            st_next       = '0;
        end
    end

endmodule

// ===== rtl/uns_emit.sv =====
// Result register: holds one bundle and sends its results one per cycle while m_ready is high.
module uns_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  uns_pkg::uns_bundle_t bundle,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output uns_pkg::uns_out_t    m_data
);
    import uns_pkg::*;

    logic        valid_reg, valid_next;
    logic [2:0]  idx_reg, idx_next;
    uns_bundle_t bundle_reg, bundle_next;
    logic [2:0]  total;
    logic        is_last;
    logic        is_char;
    logic        taken;

    assign total    = bundle_reg.nchar + {2'd0, bundle_reg.done};
    assign is_last  = (idx_reg == total - 3'd1);
    assign is_char  = (idx_reg < bundle_reg.nchar);
    assign taken    = valid_reg && m_ready;
    assign can_load = !valid_reg || (m_ready && is_last);

    // Select the current result
    assign m_valid           = valid_reg;
    assign m_data.out_byte   = is_char ? bundle_reg.chars[idx_reg] : 8'd0;
    assign m_data.out_done   = !is_char;
    assign m_data.out_length = is_char ? 9'd0 : bundle_reg.length;
    assign m_data.out_last   = is_last;

    // Advance through the bundle, reload on the last result
    always_comb begin
        valid_next  = valid_reg;
        idx_next    = idx_reg;
        bundle_next = bundle_reg;
        if (taken) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (load) begin
            valid_next  = 1'b1;
            idx_next    = 3'd0;
            bundle_next = bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
        bundle_reg <= bundle_next;
    end

endmodule

// ===== rtl/utf8_name_sanitizer_unit.sv =====
// Top level of the UTF-8 name sanitizer: config registers, name state, decode and result stage.
//
//   channel   direction  handshake               payload
//   s_        in         s_valid / s_ready       s_data   (uns_in_t: in_byte, in_last)
//   m_        out        m_valid / m_ready       m_data   (uns_out_t: byte, done, length, last)
//   cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request is decoded combinationally against the name state and its results are registered.
// With m_ready high, results leave at one per cycle and a request with 0 or 1 result is taken
// every cycle; one with k results (0 to 6) keeps the stage until its last result is taken.
// The next request is taken in the cycle its predecessor's last result is taken.
// Reset clears the name state, empties the result stage and loads capacity 64, limit 32.
// m_ready low holds the current result and stalls s_ready once the stage is full.
module utf8_name_sanitizer_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  uns_pkg::uns_in_t                       s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output uns_pkg::uns_out_t                      m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [uns_pkg::UNS_CFG_INDEX_W-1:0]    cfg_index,
    input  logic [8:0]                             cfg_data
);
    import uns_pkg::*;

    logic [8:0]  capacity_reg, capacity_next;
    logic [7:0]  limit_reg, limit_next;
    uns_state_t  state_reg, state_next;
    uns_state_t  decoded;
    uns_bundle_t bundle;
    logic        accept;
    logic        load;
    logic        can_load;

    assign cfg_ready = 1'b1;
    assign s_ready   = can_load;
    assign accept    = s_valid && s_ready;
    assign load      = accept && (bundle.nchar != 3'd0 || bundle.done);

    uns_decode u_decode (
        .st            (state_reg),
        .req           (s_data),
        .byte_capacity (capacity_reg),
        .char_limit    (limit_reg),
        .st_next       (decoded),
        .bundle        (bundle)
    );

    uns_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .bundle   (bundle),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Write config registers, advance name state on each request
    always_comb begin
        capacity_next = capacity_reg;
        limit_next    = limit_reg;
        state_next    = accept ? decoded : state_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                UNS_REG_BYTE_CAPACITY: capacity_next = cfg_data;
                UNS_REG_CHAR_LIMIT:    limit_next    = cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= UNS_CAPACITY_RESET;
            limit_reg    <= UNS_LIMIT_RESET;
            state_reg    <= '0;
        end else begin
            capacity_reg <= capacity_next;
            limit_reg    <= limit_next;
            state_reg    <= state_next;
        end
    end

endmodule

// ===== rtl/uns_checker.sv =====
// Port-level checks for the UTF-8 name sanitizer, bound to the top level.
module uns_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input uns_pkg::uns_out_t m_data
);
    import uns_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Empty result stage after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Close item ends its request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_done |-> m_data.out_last && m_data.out_byte == 8'd0)
        else $error("close item not last or carries a byte");

    // Character bytes carry no length and are never zero
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_done |-> m_data.out_length == 9'd0
                                        && m_data.out_byte != 8'd0)
        else $error("malformed character result");

endmodule

bind utf8_name_sanitizer_unit uns_checker u_uns_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the UTF-8 name sanitizer: directed table, random names, predictor.
`timescale 1ns / 100ps

module testbench;
    import uns_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PCT       = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_ITEMS   = 480;
    localparam int MAX_PRINTS     = 50;
    localparam int WIDE_TOKENS    = 66;

    // Byte classes used by the predictor and the name generator.
    localparam logic [7:0] ASCII_TOP  = 8'h80;
    localparam logic [1:0] CONT_TAG   = 2'b10;
    localparam logic [7:0] PRINT_LO   = 8'h21;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] STRAY_LO   = 8'hF5;
    localparam logic [7:0] STRAY_HI   = 8'hFF;
    localparam logic [7:0] BAD_LEAD   = 8'hC0;
    localparam logic [7:0] NUL_BYTE   = 8'h00;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [UNS_CFG_INDEX_W-1:0] UNUSED_REG = UNS_CFG_INDEX_W'(5);

    // Directed table: byte, last flag, and a typed-in close length where one is given.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       fixed;
        logic [8:0] length;
    } dir_row_t;

    typedef struct packed {
        logic       fixed;
        logic [8:0] length;
    } row_note_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 9'd0},  // zero byte right after reset: empty name
        '{8'hFF, 1'b1, 1'b1, 9'd0},  // invalid lead as the whole name
        '{8'h00, 1'b1, 1'b1, 9'd0},  // zero byte carrying last: one close only
        '{8'h20, 1'b0, 1'b0, 9'd0},  // leading space
        '{8'h09, 1'b0, 1'b0, 9'd0},  // leading tab
        '{8'h41, 1'b0, 1'b0, 9'd0},  // first visible character
        '{8'h0D, 1'b0, 1'b0, 9'd0},  // CR: dropped, no space
        '{8'h7F, 1'b0, 1'b0, 9'd0},  // DEL
        '{8'h20, 1'b0, 1'b0, 9'd0},  // space between words
        '{8'hC3, 1'b0, 1'b0, 9'd0},  // two-byte lead
        '{8'hA9, 1'b0, 1'b0, 9'd0},
        '{8'hE2, 1'b0, 1'b0, 9'd0},  // three-byte character
        '{8'h82, 1'b0, 1'b0, 9'd0},
        '{8'hAC, 1'b0, 1'b0, 9'd0},
        '{8'hF0, 1'b0, 1'b0, 9'd0},  // four-byte character
        '{8'h9F, 1'b0, 1'b0, 9'd0},
        '{8'h98, 1'b0, 1'b0, 9'd0},
        '{8'h80, 1'b0, 1'b0, 9'd0},
        '{8'hC2, 1'b0, 1'b0, 9'd0},  // C1 control, dropped
        '{8'h85, 1'b0, 1'b0, 9'd0},
        '{8'h80, 1'b0, 1'b0, 9'd0},  // continuation with no lead
        '{8'hE0, 1'b0, 1'b0, 9'd0},  // broken sequence, Z taken as a new lead
        '{8'h5A, 1'b0, 1'b0, 9'd0},
        '{8'hF4, 1'b0, 1'b0, 9'd0},  // sequence still open at the end of the name
        '{8'h8F, 1'b1, 1'b0, 9'd0}
    };

    // Fixed settings first, extremes among them; random settings follow.
    localparam int FIXED_PHASES = 8;
    localparam int HOLD_PHASE   = 1;
    localparam int QUIET_PHASE  = 6;
    localparam logic [8:0] PHASE_CAP [FIXED_PHASES] = '{
        9'd256, 9'd511, 9'd0, 9'd1, 9'd2, 9'd64, 9'd12, 9'd300
    };
    localparam logic [8:0] PHASE_LIM [FIXED_PHASES] = '{
        9'd255, 9'h1FF, 9'd32, 9'd255, 9'd1, 9'd0, 9'd5, 9'h10A
    };

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    uns_in_t                    s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    uns_out_t                   m_data;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [UNS_CFG_INDEX_W-1:0] cfg_index = '0;
    logic [8:0]                 cfg_data  = '0;

    // Predictor copy of the registers and of the per-name state.
    logic [8:0] cap_reg   = UNS_CAPACITY_RESET;
    logic [7:0] limit_reg = UNS_LIMIT_RESET;
    logic [7:0] lead_b;
    logic [7:0] cont_b [3];
    int         seq_len;
    int         cont_n;
    bit         gap_pending;
    int         out_bytes;
    int         out_chars;
    bit         stopped;

    uns_out_t   step_buf [$];
    uns_out_t   cleaned_q [$];
    row_note_t  row_note_q [$];

    int         mismatch_count = 0;
    int         random_items   = 0;
    bit         no_idle        = 1'b0;
    int         hold_req       = 0;

    utf8_name_sanitizer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin : clock_gen
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // ---------------- predictor ----------------

    function automatic void put_out(input logic [7:0] b, input logic d, input logic [8:0] n);
        uns_out_t r;
        r.out_byte   = b;
        r.out_done   = d;
        r.out_length = n;
        r.out_last   = 1'b0;
        step_buf.push_back(r);
    endfunction

    function automatic void clear_name_state();
        lead_b      = '0;
        cont_b[0]   = '0;
        cont_b[1]   = '0;
        cont_b[2]   = '0;
        seq_len     = 0;
        cont_n      = 0;
        gap_pending = 1'b0;
        out_bytes   = 0;
        out_chars   = 0;
        stopped     = 1'b0;
    endfunction

    // Emit one whole character, with the pending space ahead of it, or halt the name.
    function automatic void place_char(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2, input logic [7:0] c3,
                                       input int len);
        int cap_eff;
        int sp;
        cap_eff = (int'(cap_reg) > UNS_MAX_CAPACITY) ? UNS_MAX_CAPACITY : int'(cap_reg);
        sp = (gap_pending && out_bytes > 0) ? 1 : 0;
        if (out_chars + 1 + sp > int'(limit_reg) || out_bytes + len + sp + 1 > cap_eff) begin
            stopped = 1'b1;
            return;
        end
        if (sp != 0) begin
            put_out(UNS_SPACE, 1'b0, 9'd0);
            out_bytes++;
            out_chars++;
        end
        gap_pending = 1'b0;
        put_out(c0, 1'b0, 9'd0);
        if (len > 1) put_out(c1, 1'b0, 9'd0);
        if (len > 2) put_out(c2, 1'b0, 9'd0);
        if (len > 3) put_out(c3, 1'b0, 9'd0);
        out_bytes += len;
        out_chars++;
    endfunction

    // Classify a byte as the start of a character.
    function automatic void take_first(input logic [7:0] b);
        if (b < ASCII_TOP) begin
            if (b < UNS_SPACE || b == UNS_DEL) begin
                if (b == UNS_TAB) gap_pending = 1'b1;
            end else if (b == UNS_SPACE) begin
                gap_pending = 1'b1;
            end else begin
                place_char(b, 8'h00, 8'h00, 8'h00, 1);
            end
            return;
        end
        if (b >= UNS_LEAD2_LO && b <= UNS_LEAD2_HI) seq_len = 2;
        else if (b >= UNS_LEAD3_LO && b <= UNS_LEAD3_HI) seq_len = 3;
        else if (b >= UNS_LEAD4_LO && b <= UNS_LEAD4_HI) seq_len = 4;
        else return;
        lead_b = b;
        cont_n = 0;
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        int len;
        if (seq_len != 0) begin
            if (b[7:6] == CONT_TAG && cont_n < 3) begin
                cont_b[cont_n] = b;
                cont_n++;
                if (cont_n + 1 >= seq_len) begin
                    len     = seq_len;
                    seq_len = 0;
                    cont_n  = 0;
                    // drop C1 controls encoded as C2 80..9F
                    if (!(lead_b == UNS_LEAD2_LO && cont_b[0] <= UNS_C1_TOP))
                        place_char(lead_b, cont_b[0], cont_b[1], cont_b[2], len);
                end
                return;
            end
            // broken sequence: drop it and look at this byte again
            seq_len = 0;
            cont_n  = 0;
        end
        take_first(b);
    endfunction

    // Work out every result one accepted request causes, last flag included.
    function automatic void predict_cleaned(input uns_in_t req);
        uns_out_t r;
        bit closing;
        step_buf.delete();
        closing = req.in_last || req.in_byte == NUL_BYTE;
        if (!stopped && req.in_byte != NUL_BYTE) feed_byte(req.in_byte);
        if (closing) begin
            put_out(8'h00, 1'b1, out_bytes[8:0]);
            clear_name_state();
        end
        if (step_buf.size() > 0) begin
            r = step_buf.pop_back();
            r.out_last = 1'b1;
            step_buf.push_back(r);
        end
    endfunction

    // ---------------- monitor and scoreboard ----------------

    initial clear_name_state();

    always @(posedge aclk) begin
        uns_out_t  got;
        uns_out_t  want;
        row_note_t note;
        if (aresetn) begin
            // check a result against the oldest expectation
            if (m_valid && m_ready) begin
                got = m_data;
                if (cleaned_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result byte %h done %b length %0d",
                                              got.out_byte, got.out_done, got.out_length));
                end else begin
                    want = cleaned_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.out_done !== want.out_done ||
                        got.out_length !== want.out_length || got.out_last !== want.out_last)
                        report_mismatch($sformatf(
                            "byte %h/%h done %b/%b length %0d/%0d last %b/%b (got/want)",
                            got.out_byte, want.out_byte, got.out_done, want.out_done,
                            got.out_length, want.out_length, got.out_last, want.out_last));
                end
            end
            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    UNS_REG_BYTE_CAPACITY: cap_reg = cfg_data;
                    UNS_REG_CHAR_LIMIT:    limit_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            // predict the results of an accepted request
            if (s_valid && s_ready) begin
                predict_cleaned(s_data);
                note = (row_note_q.size() != 0) ? row_note_q.pop_front() : '0;
                if (note.fixed) begin
                    want.out_byte   = 8'h00;
                    want.out_done   = 1'b1;
                    want.out_length = note.length;
                    want.out_last   = 1'b1;
                    cleaned_q.push_back(want);
                end else begin
                    foreach (step_buf[i]) cleaned_q.push_back(step_buf[i]);
                end
            end
        end
    end

    // ---------------- result sink ----------------

    initial begin : result_sink
        int held;
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                // hold off for a long stretch so the block fills and stalls its input
                hold_seen = hold_req;
                m_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge aclk);
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    // ---------------- stimulus helpers ----------------

    // Offer one request, starting at a falling edge; returns at the falling edge after it is taken.
    task automatic send_request(input uns_in_t req);
        int gap;
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [UNS_CFG_INDEX_W-1:0] idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic configure(input logic [8:0] cap, input logic [8:0] lim, input bit extra);
        write_reg(UNS_REG_BYTE_CAPACITY, cap);
        write_reg(UNS_REG_CHAR_LIMIT, lim);
        if (extra) write_reg(UNUSED_REG, 9'h1FF);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the block settle; returns at a falling edge.
    task automatic settle();
        while (cleaned_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] cont_byte();
        return {CONT_TAG, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_of(input int len);
        if (len == 2) return 8'($urandom_range(UNS_LEAD2_LO, UNS_LEAD2_HI));
        if (len == 3) return 8'($urandom_range(UNS_LEAD3_LO, UNS_LEAD3_HI));
        return 8'($urandom_range(UNS_LEAD4_LO, UNS_LEAD4_HI));
    endfunction

    // Build one name from random tokens, mostly well formed, and send it.
    task automatic send_name(input int tokens, input bit wide);
        logic [7:0] bytes_q [$];
        int         k;
        int         j;
        int         pick;
        int         len;
        int         ending;
        bit         mark_last;
        uns_in_t    req;
        row_note_t  note;
        for (k = 0; k < tokens; k++) begin
            pick = wide ? 75 : $urandom_range(0, 99);
            if (pick < 40) begin
                bytes_q.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
            end else if (pick < 55) begin
                bytes_q.push_back(($urandom_range(0, 1) == 0) ? UNS_SPACE : UNS_TAB);
            end else if (pick < 80) begin
                // whole character of 2, 3 or 4 bytes
                len = (pick < 65) ? 2 : (pick < 73) ? 3 : 4;
                bytes_q.push_back(lead_of(len));
                for (j = 1; j < len; j++) bytes_q.push_back(cont_byte());
            end else if (pick < 85) begin
                bytes_q.push_back(UNS_LEAD2_LO);
                bytes_q.push_back(8'($urandom_range(ASCII_TOP, UNS_C1_TOP)));
            end else if (pick < 90) begin
                // broken sequence: lead, some continuations, then a non-continuation
                len = $urandom_range(2, 4);
                bytes_q.push_back(lead_of(len));
                for (j = $urandom_range(0, len - 2); j > 0; j--) bytes_q.push_back(cont_byte());
                bytes_q.push_back({($urandom_range(0, 1) == 0) ? 2'b01 : 2'b11, 6'($urandom)});
            end else if (pick < 95) begin
                case ($urandom_range(0, 2))
                    0: bytes_q.push_back(cont_byte());
                    1: bytes_q.push_back(BAD_LEAD | 8'($urandom_range(0, 1)));
                    default: bytes_q.push_back(8'($urandom_range(STRAY_LO, STRAY_HI)));
                endcase
            end else begin
                bytes_q.push_back(8'($urandom_range(1, 255)));
            end
        end
        // close the name: last flag, zero byte, zero with last, or any byte with last
        ending = $urandom_range(0, 99);
        mark_last = 1'b1;
        if (ending < 55) begin
            mark_last = 1'b1;
        end else if (ending < 75) begin
            bytes_q.push_back(NUL_BYTE);
            mark_last = 1'b0;
        end else if (ending < 88) begin
            bytes_q.push_back(NUL_BYTE);
        end else begin
            bytes_q.push_back(8'($urandom_range(0, 255)));
        end
        note = '0;
        for (k = 0; k < bytes_q.size(); k++) begin
            req.in_byte = bytes_q[k];
            req.in_last = mark_last && (k == bytes_q.size() - 1);
            row_note_q.push_back(note);
            send_request(req);
            random_items++;
        end
    endtask

    // ---------------- main sequence ----------------

    initial begin : stimulus
        int        r;
        int        n;
        int        phase;
        int        drain;
        logic [8:0] cap;
        logic [8:0] lim;
        uns_in_t   req;
        row_note_t note;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table at the reset settings
        for (r = 0; r < DIR_ROWS; r++) begin
            req.in_byte = DIR_TABLE[r].code;
            req.in_last = DIR_TABLE[r].last;
            note.fixed  = DIR_TABLE[r].fixed;
            note.length = DIR_TABLE[r].length;
            row_note_q.push_back(note);
            send_request(req);
        end
        s_valid <= 1'b0;
        settle();

        // random names under a series of settings
        phase = 0;
        while (phase < FIXED_PHASES || random_items < RANDOM_ITEMS) begin
            if (phase < FIXED_PHASES) begin
                cap = PHASE_CAP[phase];
                lim = PHASE_LIM[phase];
            end else begin
                cap = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                  : 9'($urandom_range(3, 80));
                lim = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                  : 9'($urandom_range(1, 24));
            end
            configure(cap, lim, phase == 0);
            no_idle = (phase == QUIET_PHASE);
            if (phase == HOLD_PHASE) hold_req++;
            for (n = 0; n < 2; n++) begin
                if (phase == 0 && n == 0)
                    send_name(WIDE_TOKENS, 1'b1);  // runs into the full capacity
                else
                    send_name($urandom_range(1, 14), 1'b0);
            end
            s_valid <= 1'b0;
            settle();
            no_idle = 1'b0;
            phase++;
        end

        // drain, then keep watching for stray results
        drain = 0;
        while (cleaned_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (cleaned_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", cleaned_q.size()));

        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
